@@ hdl/fea_pkg.sv @@
// ----------------------------------------------------------------------------
// fea_pkg
// Shared types, widths and codes for the free extent allocator.
// ----------------------------------------------------------------------------
package fea_pkg;

  localparam int EXTENT_SLOTS = 64;
  localparam int IDX_W        = $clog2(EXTENT_SLOTS);
  localparam int CNT_W        = $clog2(EXTENT_SLOTS + 1);

  localparam int OP_W    = 3;
  localparam int ST_W    = 3;
  localparam int ADDR_W  = 48;
  localparam int LEN_W   = 32;
  localparam int STAMP_W = 40;
  localparam int BSL_W   = 5;
  localparam int CHG_W   = 32;
  localparam int CIDX_W  = 1;

  localparam logic [OP_W-1:0] OP_REQUEST = 3'd0;
  localparam logic [OP_W-1:0] OP_RELEASE = 3'd1;
  localparam logic [OP_W-1:0] OP_CARVE   = 3'd2;
  localparam logic [OP_W-1:0] OP_INSERT  = 3'd3;
  localparam logic [OP_W-1:0] OP_CLEAR   = 3'd4;

  localparam logic [ST_W-1:0] ST_OK      = 3'd0;
  localparam logic [ST_W-1:0] ST_EMPTY   = 3'd1;
  localparam logic [ST_W-1:0] ST_FULL    = 3'd2;
  localparam logic [ST_W-1:0] ST_NOCOVER = 3'd3;
  localparam logic [ST_W-1:0] ST_DUP     = 3'd4;

  localparam logic [CIDX_W-1:0] CFG_BLOCK_LOG2 = 1'd0;
  localparam logic [CIDX_W-1:0] CFG_MAX_EXTENT = 1'd1;

  localparam logic [BSL_W-1:0] BSL_RESET = 5'd12;
  localparam logic [LEN_W-1:0] MAX_RESET = 32'd16777216;

  typedef struct packed {
    logic latch;
    logic scan;
    logic eval;
    logic wr1;
    logic wr2;
  } cmd_t;

  typedef struct packed {
    logic scan_done;
  } sts_t;

  typedef struct packed {
    logic [ADDR_W-1:0]  start;
    logic [LEN_W-1:0]   len;
    logic [STAMP_W-1:0] stamp;
  } ent_t;

endpackage

@@ hdl/free_extent_allocator.sv @@
// ----------------------------------------------------------------------------
// free_extent_allocator
// Best-fit allocator over a table of free extents with neighbor merging.
//
// A command word is taken when start is high and busy is low: in_operation
// selects request, release, carve, insert or clear, with in_address and
// in_num_bytes as arguments. Each command gives exactly one result word,
// shown for one cycle with out_valid high; the receiver cannot stall it.
// out_valid rises after the scan of the 64-entry extent memory, one slot per
// cycle through its registered read port, then evaluation and two write
// steps; a new command is taken only after the strobe, once busy is low, and
// busy is high from acceptance through the strobe. Register writes go through
// cfg_valid/cfg_ready (always ready), index 0 the block size log2, index 1
// the merge limit; the user must make them only while idle, as the block
// itself does not enforce it.
// Reset empties the table, zeroes the counters and loads block size 4 KiB
// and a 16 MiB merge limit; no clearing pass is needed.
// ----------------------------------------------------------------------------
module free_extent_allocator (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  logic [fea_pkg::OP_W-1:0]      in_operation,
  input  logic [fea_pkg::ADDR_W-1:0]    in_address,
  input  logic [fea_pkg::LEN_W-1:0]     in_num_bytes,
  output logic                          out_valid,
  output logic [fea_pkg::ST_W-1:0]      out_status,
  output logic [fea_pkg::ADDR_W-1:0]    out_grant_address,
  output logic [fea_pkg::LEN_W-1:0]     out_grant_bytes,
  output logic [fea_pkg::ADDR_W-1:0]    out_free_bytes_total,
  output logic [fea_pkg::CNT_W-1:0]     out_extent_count,
  output logic [fea_pkg::CHG_W-1:0]     out_change_count,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [fea_pkg::CIDX_W-1:0]    cfg_index,
  input  logic [fea_pkg::LEN_W-1:0]     cfg_data
);

  fea_pkg::cmd_t cmd;
  fea_pkg::sts_t sts;

  fea_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .out_valid (out_valid),
    .sts       (sts),
    .cmd       (cmd)
  );

  fea_dp u_dp (
    .clk                  (clk),
    .rst_n                (rst_n),
    .cmd                  (cmd),
    .sts                  (sts),
    .in_operation         (in_operation),
    .in_address           (in_address),
    .in_num_bytes         (in_num_bytes),
    .cfg_valid            (cfg_valid),
    .cfg_ready            (cfg_ready),
    .cfg_index            (cfg_index),
    .cfg_data             (cfg_data),
    .out_status           (out_status),
    .out_grant_address    (out_grant_address),
    .out_grant_bytes      (out_grant_bytes),
    .out_free_bytes_total (out_free_bytes_total),
    .out_extent_count     (out_extent_count),
    .out_change_count     (out_change_count)
  );

endmodule

@@ hdl/fea_ctrl.sv @@
// ----------------------------------------------------------------------------
// fea_ctrl
// Sequencer: accept, table scan, evaluate, two write steps, result strobe.
// ----------------------------------------------------------------------------
module fea_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  output logic          busy,
  output logic          out_valid,
  input  fea_pkg::sts_t sts,
  output fea_pkg::cmd_t cmd
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_SCAN = 3'd1;
  localparam logic [2:0] S_EVAL = 3'd2;
  localparam logic [2:0] S_WR1  = 3'd3;
  localparam logic [2:0] S_WR2  = 3'd4;
  localparam logic [2:0] S_OUT  = 3'd5;

  logic [2:0] state_r;
  logic [2:0] state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          cmd.latch = 1'b1;
          state_nxt = S_SCAN;
        end
      end
      S_SCAN: begin
        cmd.scan = 1'b1;
        if (sts.scan_done) state_nxt = S_EVAL;
      end
      S_EVAL: begin
        cmd.eval  = 1'b1;
        state_nxt = S_WR1;
      end
      S_WR1: begin
        cmd.wr1   = 1'b1;
        state_nxt = S_WR2;
      end
      S_WR2: begin
        cmd.wr2   = 1'b1;
        state_nxt = S_OUT;
      end
      S_OUT:   state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_IDLE;
    else        state_r <= state_nxt;
  end

  assign busy      = (state_r != S_IDLE);
  assign out_valid = (state_r == S_OUT);

endmodule

@@ hdl/fea_dp.sv @@
// ----------------------------------------------------------------------------
// fea_dp
// Extent table memory, scan comparators, decision logic and counters.
// ----------------------------------------------------------------------------
module fea_dp (
  input  logic                          clk,
  input  logic                          rst_n,
  input  fea_pkg::cmd_t                 cmd,
  output fea_pkg::sts_t                 sts,
  input  logic [fea_pkg::OP_W-1:0]      in_operation,
  input  logic [fea_pkg::ADDR_W-1:0]    in_address,
  input  logic [fea_pkg::LEN_W-1:0]     in_num_bytes,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [fea_pkg::CIDX_W-1:0]    cfg_index,
  input  logic [fea_pkg::LEN_W-1:0]     cfg_data,
  output logic [fea_pkg::ST_W-1:0]      out_status,
  output logic [fea_pkg::ADDR_W-1:0]    out_grant_address,
  output logic [fea_pkg::LEN_W-1:0]     out_grant_bytes,
  output logic [fea_pkg::ADDR_W-1:0]    out_free_bytes_total,
  output logic [fea_pkg::CNT_W-1:0]     out_extent_count,
  output logic [fea_pkg::CHG_W-1:0]     out_change_count
);

  localparam int SLOTS = fea_pkg::EXTENT_SLOTS;
  localparam int IW    = fea_pkg::IDX_W;
  localparam int CW    = fea_pkg::CNT_W;
  localparam int AW    = fea_pkg::ADDR_W;
  localparam int LW    = fea_pkg::LEN_W;
  localparam int SW    = fea_pkg::STAMP_W;

  // configuration
  logic [fea_pkg::BSL_W-1:0] bsl_r;
  logic [LW-1:0]             max_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bsl_r <= fea_pkg::BSL_RESET;
      max_r <= fea_pkg::MAX_RESET;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        fea_pkg::CFG_BLOCK_LOG2: bsl_r <= cfg_data[fea_pkg::BSL_W-1:0];
        fea_pkg::CFG_MAX_EXTENT: max_r <= cfg_data;
        default: ;
      endcase
    end
  end

  logic [LW:0] bs_mask;
  logic [LW:0] bs;
  logic [LW:0] rsum;
  assign bs_mask = (33'd1 << bsl_r) - 33'd1;
  assign bs      = bs_mask + 33'd1;
  assign rsum    = {1'b0, in_num_bytes} + bs_mask;

  // command word
  logic [fea_pkg::OP_W-1:0] op_r;
  logic [AW-1:0]            addr_r;
  logic [LW-1:0]            n_r;
  logic [LW:0]              rnd_r;

  // table
  fea_pkg::ent_t mem [SLOTS];
  fea_pkg::ent_t rd_data_r;
  logic [SLOTS-1:0] valid_r;
  logic [SLOTS-1:0] valid_nxt;

  // scan
  logic [CW-1:0] cnt_r;
  logic          p_r;
  logic [IW-1:0] p_idx_r;

  logic          ge_f_r, lt_f_r, dup_r, prv_f_r, nxt_f_r, hst_f_r, fr0_f_r, fr1_f_r;
  logic [IW-1:0] ge_idx_r, lt_idx_r, prv_idx_r, nxt_idx_r, hst_idx_r, fr0_idx_r, fr1_idx_r;
  logic [LW-1:0] ge_len_r, lt_len_r, prv_len_r, nxt_len_r, hst_len_r;
  logic [SW-1:0] ge_stamp_r, lt_stamp_r;
  logic [AW-1:0] ge_start_r, lt_start_r, prv_start_r, nxt_start_r, hst_start_r;

  // decision
  logic [fea_pkg::ST_W-1:0] st_r, e_st;
  logic [AW-1:0] ga_r, e_ga;
  logic [LW-1:0] gb_r, e_gb;
  logic          chg_r, e_chg, clr_r, e_clr;
  logic          da_f_r, e_da_f, db_f_r, e_db_f, pl1_r, e_pl1, pl2_r, e_pl2;
  logic [IW-1:0] da_idx_r, e_da_idx, db_idx_r, e_db_idx, s1_r, e_s1, s2_r, e_s2;
  logic [LW-1:0] da_len_r, e_da_len, db_len_r, e_db_len;
  logic [AW-1:0] p1s_r, e_p1s, p2s_r, e_p2s;
  logic [LW-1:0] p1l_r, e_p1l, p2l_r, e_p2l;

  // state
  logic [AW-1:0]            ft_r;
  logic [CW-1:0]            vc_r;
  logic [SW-1:0]            stamp_r;
  logic [fea_pkg::CHG_W-1:0] chgcnt_r;

  assign sts.scan_done = (cnt_r == CW'(SLOTS)) && !p_r;

  fea_pkg::ent_t e;
  logic          ev;
  assign e  = rd_data_r;
  assign ev = valid_r[p_idx_r];

  // memory
  logic          mem_we;
  logic [IW-1:0] mem_wa;
  fea_pkg::ent_t mem_wd;
  assign mem_we = (cmd.wr1 && pl1_r) || (cmd.wr2 && pl2_r);
  assign mem_wa = cmd.wr2 ? s2_r : s1_r;
  assign mem_wd = cmd.wr2 ? '{start: p2s_r, len: p2l_r, stamp: stamp_r}
                          : '{start: p1s_r, len: p1l_r, stamp: stamp_r};

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_wa] <= mem_wd;
    if (cmd.scan) rd_data_r <= mem[cnt_r[IW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
      p_r   <= 1'b0;
    end else if (cmd.latch) begin
      cnt_r <= '0;
      p_r   <= 1'b0;
    end else if (cmd.scan) begin
      if (cnt_r != CW'(SLOTS)) begin
        cnt_r <= cnt_r + CW'(1);
        p_r   <= 1'b1;
      end else begin
        p_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.scan) p_idx_r <= cnt_r[IW-1:0];
    if (cmd.latch) begin
      op_r    <= in_operation;
      addr_r  <= in_address;
      n_r     <= in_num_bytes;
      rnd_r   <= rsum & ~bs_mask;
      ge_f_r  <= 1'b0;
      lt_f_r  <= 1'b0;
      dup_r   <= 1'b0;
      prv_f_r <= 1'b0;
      nxt_f_r <= 1'b0;
      hst_f_r <= 1'b0;
      fr0_f_r <= 1'b0;
      fr1_f_r <= 1'b0;
    end else if (cmd.scan && p_r) begin
      if (ev) begin
        if ({1'b0, e.len} >= rnd_r) begin
          if (!ge_f_r || e.len < ge_len_r ||
              (e.len == ge_len_r && e.stamp > ge_stamp_r)) begin
            ge_f_r     <= 1'b1;
            ge_idx_r   <= p_idx_r;
            ge_len_r   <= e.len;
            ge_stamp_r <= e.stamp;
            ge_start_r <= e.start;
          end
        end else if (!lt_f_r || e.len > lt_len_r ||
                     (e.len == lt_len_r && e.stamp > lt_stamp_r)) begin
          lt_f_r     <= 1'b1;
          lt_idx_r   <= p_idx_r;
          lt_len_r   <= e.len;
          lt_stamp_r <= e.stamp;
          lt_start_r <= e.start;
        end
        if (e.start == addr_r) dup_r <= 1'b1;
        if (e.start < addr_r && (!prv_f_r || e.start > prv_start_r)) begin
          prv_f_r     <= 1'b1;
          prv_idx_r   <= p_idx_r;
          prv_start_r <= e.start;
          prv_len_r   <= e.len;
        end
        if (e.start > addr_r && (!nxt_f_r || e.start < nxt_start_r)) begin
          nxt_f_r     <= 1'b1;
          nxt_idx_r   <= p_idx_r;
          nxt_start_r <= e.start;
          nxt_len_r   <= e.len;
        end
        if (e.start <= addr_r && (!hst_f_r || e.start > hst_start_r)) begin
          hst_f_r     <= 1'b1;
          hst_idx_r   <= p_idx_r;
          hst_start_r <= e.start;
          hst_len_r   <= e.len;
        end
      end else if (!fr0_f_r) begin
        fr0_f_r   <= 1'b1;
        fr0_idx_r <= p_idx_r;
      end else if (!fr1_f_r) begin
        fr1_f_r   <= 1'b1;
        fr1_idx_r <= p_idx_r;
      end
    end
  end

  // evaluation
  logic          pk_f;
  logic [IW-1:0] pk_idx;
  logic [LW-1:0] pk_len;
  logic [AW-1:0] pk_start;
  logic [LW:0]   rq_left;
  logic [LW:0]   pn_sum;
  logic [AW:0]   prv_end, q_end, h_end;
  logic          mp, mn, full;
  logic [LW:0]   rl_len;
  logic [LW+1:0] all_sum;
  logic          s1_f;

  assign pk_f     = ge_f_r | lt_f_r;
  assign pk_idx   = ge_f_r ? ge_idx_r : lt_idx_r;
  assign pk_len   = ge_f_r ? ge_len_r : lt_len_r;
  assign pk_start = ge_f_r ? ge_start_r : lt_start_r;
  assign rq_left  = {1'b0, pk_len} - rnd_r;
  assign pn_sum   = {1'b0, prv_len_r} + {1'b0, n_r};
  assign prv_end  = {1'b0, prv_start_r} + {17'd0, prv_len_r};
  assign q_end    = {1'b0, addr_r} + {17'd0, n_r};
  assign h_end    = {1'b0, hst_start_r} + {17'd0, hst_len_r};
  assign mp       = prv_f_r && (prv_end == {1'b0, addr_r}) && (pn_sum < {1'b0, max_r});
  assign rl_len   = mp ? pn_sum : {1'b0, n_r};
  assign all_sum  = {1'b0, rl_len} + {2'b0, nxt_len_r};
  assign mn       = nxt_f_r && (q_end == {1'b0, nxt_start_r}) && (all_sum < {2'b0, max_r});
  assign full     = (vc_r >= CW'(SLOTS));

  always_comb begin
    e_st     = fea_pkg::ST_OK;
    e_ga     = '0;
    e_gb     = '0;
    e_chg    = 1'b0;
    e_clr    = 1'b0;
    e_da_f   = 1'b0;
    e_da_idx = hst_idx_r;
    e_da_len = hst_len_r;
    e_db_f   = 1'b0;
    e_db_idx = nxt_idx_r;
    e_db_len = nxt_len_r;
    e_pl1    = 1'b0;
    e_pl2    = 1'b0;
    e_p1s    = addr_r;
    e_p1l    = n_r;
    e_p2s    = q_end[AW-1:0];
    e_p2l    = LW'(h_end - q_end);
    unique case (op_r)
      fea_pkg::OP_REQUEST: begin
        if (!pk_f) begin
          e_st = fea_pkg::ST_EMPTY;
        end else begin
          e_chg    = 1'b1;
          e_ga     = pk_start;
          e_da_f   = 1'b1;
          e_da_idx = pk_idx;
          e_da_len = pk_len;
          if (({1'b0, pk_len} < rnd_r) || (rq_left < bs)) begin
            e_gb = pk_len;
          end else begin
            e_gb  = rnd_r[LW-1:0];
            e_pl1 = 1'b1;
            e_p1s = pk_start + {16'd0, rnd_r[LW-1:0]};
            e_p1l = rq_left[LW-1:0];
          end
        end
      end
      fea_pkg::OP_RELEASE: begin
        if (dup_r) begin
          e_st = fea_pkg::ST_DUP;
        end else if (!mp && !mn && full) begin
          e_st = fea_pkg::ST_FULL;
        end else begin
          e_chg    = 1'b1;
          e_da_f   = mp;
          e_da_idx = prv_idx_r;
          e_da_len = prv_len_r;
          e_db_f   = mn;
          e_pl1    = 1'b1;
          e_p1s    = mp ? prv_start_r : addr_r;
          e_p1l    = mn ? all_sum[LW-1:0] : rl_len[LW-1:0];
        end
      end
      fea_pkg::OP_CARVE: begin
        if (!hst_f_r || (q_end > h_end)) begin
          e_st = fea_pkg::ST_NOCOVER;
        end else if (hst_start_r == addr_r) begin
          e_da_f = 1'b1;
          e_pl1  = (hst_len_r != n_r);
          e_p1s  = q_end[AW-1:0];
          e_p1l  = hst_len_r - n_r;
        end else if (h_end == q_end) begin
          e_da_f = 1'b1;
          e_pl1  = 1'b1;
          e_p1s  = hst_start_r;
          e_p1l  = hst_len_r - n_r;
        end else if (full) begin
          e_st = fea_pkg::ST_FULL;
        end else begin
          e_da_f = 1'b1;
          e_pl1  = 1'b1;
          e_p1s  = hst_start_r;
          e_p1l  = LW'(addr_r - hst_start_r);
          e_pl2  = 1'b1;
        end
      end
      fea_pkg::OP_INSERT: begin
        if (dup_r)      e_st = fea_pkg::ST_DUP;
        else if (full)  e_st = fea_pkg::ST_FULL;
        else            e_pl1 = 1'b1;
      end
      fea_pkg::OP_CLEAR: e_clr = 1'b1;
      default: ;
    endcase

    // lowest free slot once the dropped ones are returned
    s1_f = fr0_f_r;
    e_s1 = fr0_idx_r;
    if (e_da_f && (!s1_f || e_da_idx < e_s1)) begin
      s1_f = 1'b1;
      e_s1 = e_da_idx;
    end
    if (e_db_f && (!s1_f || e_db_idx < e_s1)) begin
      e_s1 = e_db_idx;
    end
    if (!fr0_f_r || e_da_idx < fr0_idx_r) e_s2 = fr0_idx_r;
    else if (fr1_f_r && fr1_idx_r < e_da_idx) e_s2 = fr1_idx_r;
    else e_s2 = e_da_idx;
  end

  always_ff @(posedge clk) begin
    if (cmd.eval) begin
      st_r     <= e_st;
      ga_r     <= e_ga;
      gb_r     <= e_gb;
      chg_r    <= e_chg;
      clr_r    <= e_clr;
      da_f_r   <= e_da_f;
      da_idx_r <= e_da_idx;
      da_len_r <= e_da_len;
      db_f_r   <= e_db_f;
      db_idx_r <= e_db_idx;
      db_len_r <= e_db_len;
      pl1_r    <= e_pl1;
      pl2_r    <= e_pl2;
      s1_r     <= e_s1;
      s2_r     <= e_s2;
      p1s_r    <= e_p1s;
      p1l_r    <= e_p1l;
      p2s_r    <= e_p2s;
      p2l_r    <= e_p2l;
    end
  end

  always_comb begin
    valid_nxt = valid_r;
    if (cmd.wr1) begin
      if (clr_r) begin
        valid_nxt = '0;
      end else begin
        if (da_f_r) valid_nxt[da_idx_r] = 1'b0;
        if (db_f_r) valid_nxt[db_idx_r] = 1'b0;
        if (pl1_r)  valid_nxt[s1_r]     = 1'b1;
      end
    end else if (cmd.wr2 && pl2_r) begin
      valid_nxt[s2_r] = 1'b1;
    end
  end

  logic [AW-1:0] da_ext, db_ext, p1_ext, p2_ext;
  assign da_ext = da_f_r ? {16'd0, da_len_r} : '0;
  assign db_ext = db_f_r ? {16'd0, db_len_r} : '0;
  assign p1_ext = pl1_r ? {16'd0, p1l_r} : '0;
  assign p2_ext = {16'd0, p2l_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r  <= '0;
      ft_r     <= '0;
      vc_r     <= '0;
      stamp_r  <= '0;
      chgcnt_r <= '0;
    end else begin
      valid_r <= valid_nxt;
      if (cmd.wr1) begin
        if (clr_r) begin
          ft_r <= '0;
          vc_r <= '0;
        end else begin
          ft_r    <= ft_r - da_ext - db_ext + p1_ext;
          vc_r    <= vc_r - CW'(da_f_r) - CW'(db_f_r) + CW'(pl1_r);
          stamp_r <= stamp_r + SW'(pl1_r);
        end
        chgcnt_r <= chgcnt_r + fea_pkg::CHG_W'(chg_r);
      end else if (cmd.wr2 && pl2_r) begin
        ft_r    <= ft_r + p2_ext;
        vc_r    <= vc_r + CW'(1);
        stamp_r <= stamp_r + SW'(1);
      end
    end
  end

  assign out_status           = st_r;
  assign out_grant_address    = ga_r;
  assign out_grant_bytes      = gb_r;
  assign out_free_bytes_total = ft_r;
  assign out_extent_count     = vc_r;
  assign out_change_count     = chgcnt_r;

endmodule

@@ tb/sv/tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the free extent allocator. Commands are queued by
// a stimulus process and driven by a clocked driver with random gaps; a
// monitor compares each result word against an in-bench allocator model
// kept in step with every accepted command.
// ----------------------------------------------------------------------------
module tb;

  typedef struct {
    logic [fea_pkg::OP_W-1:0]   op;
    logic [fea_pkg::ADDR_W-1:0] addr;
    logic [fea_pkg::LEN_W-1:0]  nbytes;
  } cmd_word_t;

  typedef struct {
    logic [fea_pkg::ST_W-1:0]   status;
    logic [fea_pkg::ADDR_W-1:0] gaddr;
    logic [fea_pkg::LEN_W-1:0]  gbytes;
    logic [fea_pkg::ADDR_W-1:0] free_sum;
    logic [fea_pkg::CNT_W-1:0]  count;
    logic [fea_pkg::CHG_W-1:0]  changes;
  } result_word_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic [fea_pkg::OP_W-1:0] in_operation = '0;
  logic [fea_pkg::ADDR_W-1:0] in_address = '0;
  logic [fea_pkg::LEN_W-1:0] in_num_bytes = '0;
  logic out_valid;
  logic [fea_pkg::ST_W-1:0] out_status;
  logic [fea_pkg::ADDR_W-1:0] out_grant_address;
  logic [fea_pkg::LEN_W-1:0] out_grant_bytes;
  logic [fea_pkg::ADDR_W-1:0] out_free_bytes_total;
  logic [fea_pkg::CNT_W-1:0] out_extent_count;
  logic [fea_pkg::CHG_W-1:0] out_change_count;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [fea_pkg::CIDX_W-1:0] cfg_index = '0;
  logic [fea_pkg::LEN_W-1:0] cfg_data = '0;

  always #5 clk = ~clk;

  free_extent_allocator dut (.*);

  // allocator model state
  logic [fea_pkg::ADDR_W-1:0]  ext_start [fea_pkg::EXTENT_SLOTS];
  logic [fea_pkg::LEN_W-1:0]   ext_len [fea_pkg::EXTENT_SLOTS];
  logic [fea_pkg::STAMP_W-1:0] ext_stamp [fea_pkg::EXTENT_SLOTS];
  bit                          ext_live [fea_pkg::EXTENT_SLOTS];
  logic [fea_pkg::STAMP_W-1:0] next_stamp;
  logic [fea_pkg::ADDR_W-1:0]  free_sum;
  int                          live_count;
  logic [fea_pkg::CHG_W-1:0]   changes;
  int                          gran_log2;
  logic [fea_pkg::LEN_W-1:0]   merge_limit;

  cmd_word_t    pending_cmds[$];
  result_word_t expected_results[$];
  int  mismatches = 0;
  bit  failed = 0;
  bit  quiet = 0;
  bit  pause_req = 0;
  longint cycles = 0;

  function automatic void drop_ext(int i);
    ext_live[i] = 0;
    free_sum = free_sum - {16'd0, ext_len[i]};
    live_count--;
  endfunction

  function automatic void place_ext(logic [63:0] a, logic [63:0] l);
    for (int i = 0; i < fea_pkg::EXTENT_SLOTS; i++) begin
      if (!ext_live[i]) begin
        ext_live[i] = 1;
        ext_start[i] = a[fea_pkg::ADDR_W-1:0];
        ext_len[i] = l[fea_pkg::LEN_W-1:0];
        ext_stamp[i] = next_stamp;
        next_stamp = next_stamp + 40'd1;
        free_sum = free_sum + {16'd0, l[fea_pkg::LEN_W-1:0]};
        live_count++;
        return;
      end
    end
  endfunction

  function automatic int slot_at(logic [fea_pkg::ADDR_W-1:0] a);
    for (int i = 0; i < fea_pkg::EXTENT_SLOTS; i++)
      if (ext_live[i] && ext_start[i] == a) return i;
    return -1;
  endfunction

  function automatic result_word_t allocate_step(cmd_word_t c);
    result_word_t r;
    logic [63:0] bs, need, a64, n64, len64, st64, li64, lj64;
    int ge, lt, pick, prv, nxt, host;
    bit mp, mn;
    r.status = fea_pkg::ST_OK; r.gaddr = '0; r.gbytes = '0;
    a64 = {16'd0, c.addr};
    n64 = {32'd0, c.nbytes};
    case (c.op)
      fea_pkg::OP_REQUEST: begin
        bs = 64'd1 << gran_log2;
        need = ((n64 + bs - 64'd1) >> gran_log2) << gran_log2;
        ge = -1; lt = -1;
        for (int i = 0; i < fea_pkg::EXTENT_SLOTS; i++) begin
          if (!ext_live[i]) continue;
          li64 = {32'd0, ext_len[i]};
          if (li64 >= need) begin
            if (ge < 0 || ext_len[i] < ext_len[ge] ||
                (ext_len[i] == ext_len[ge] && ext_stamp[i] > ext_stamp[ge])) ge = i;
          end else begin
            if (lt < 0 || ext_len[i] > ext_len[lt] ||
                (ext_len[i] == ext_len[lt] && ext_stamp[i] > ext_stamp[lt])) lt = i;
          end
        end
        pick = ge >= 0 ? ge : lt;
        if (pick < 0) r.status = fea_pkg::ST_EMPTY;
        else begin
          changes++;
          r.gaddr = ext_start[pick];
          len64 = {32'd0, ext_len[pick]};
          if (len64 < need || len64 - need < bs) begin
            r.gbytes = ext_len[pick];
            drop_ext(pick);
          end else begin
            st64 = {16'd0, ext_start[pick]};
            r.gbytes = need[fea_pkg::LEN_W-1:0];
            drop_ext(pick);
            place_ext(st64 + need, len64 - need);
          end
        end
      end
      fea_pkg::OP_RELEASE: begin
        if (slot_at(c.addr) >= 0) r.status = fea_pkg::ST_DUP;
        else begin
          prv = -1; nxt = -1; mp = 0; mn = 0;
          st64 = a64; len64 = n64;
          for (int i = 0; i < fea_pkg::EXTENT_SLOTS; i++) begin
            if (!ext_live[i]) continue;
            if (ext_start[i] < c.addr && (prv < 0 || ext_start[i] > ext_start[prv]))
              prv = i;
            if (ext_start[i] > c.addr && (nxt < 0 || ext_start[i] < ext_start[nxt]))
              nxt = i;
          end
          if (prv >= 0) begin
            li64 = {32'd0, ext_len[prv]};
            if ({16'd0, ext_start[prv]} + li64 == a64 &&
                li64 + n64 < {32'd0, merge_limit}) begin
              mp = 1; st64 = {16'd0, ext_start[prv]}; len64 = n64 + li64;
            end
          end
          if (nxt >= 0) begin
            lj64 = {32'd0, ext_len[nxt]};
            if (a64 + n64 == {16'd0, ext_start[nxt]} &&
                len64 + lj64 < {32'd0, merge_limit}) mn = 1;
          end
          if (!mp && !mn && live_count >= fea_pkg::EXTENT_SLOTS) r.status = fea_pkg::ST_FULL;
          else begin
            if (mp) drop_ext(prv);
            if (mn) begin
              len64 = len64 + {32'd0, ext_len[nxt]};
              drop_ext(nxt);
            end
            changes++;
            place_ext(st64, len64);
          end
        end
      end
      fea_pkg::OP_CARVE: begin
        host = -1;
        for (int i = 0; i < fea_pkg::EXTENT_SLOTS; i++)
          if (ext_live[i] && ext_start[i] <= c.addr &&
              (host < 0 || ext_start[i] > ext_start[host])) host = i;
        if (host < 0) r.status = fea_pkg::ST_NOCOVER;
        else begin
          st64 = {16'd0, ext_start[host]}; len64 = {32'd0, ext_len[host]};
          if (a64 + n64 > st64 + len64) r.status = fea_pkg::ST_NOCOVER;
          else if (st64 == a64) begin
            drop_ext(host);
            if (len64 != n64) place_ext(st64 + n64, len64 - n64);
          end else if (st64 + len64 == a64 + n64) begin
            drop_ext(host);
            place_ext(st64, len64 - n64);
          end else if (live_count >= fea_pkg::EXTENT_SLOTS) r.status = fea_pkg::ST_FULL;
          else begin
            drop_ext(host);
            place_ext(st64, a64 - st64);
            place_ext(a64 + n64, st64 + len64 - a64 - n64);
          end
        end
      end
      fea_pkg::OP_INSERT: begin
        if (slot_at(c.addr) >= 0) r.status = fea_pkg::ST_DUP;
        else if (live_count >= fea_pkg::EXTENT_SLOTS) r.status = fea_pkg::ST_FULL;
        else place_ext(a64, n64);
      end
      fea_pkg::OP_CLEAR: begin
        for (int i = 0; i < fea_pkg::EXTENT_SLOTS; i++) ext_live[i] = 0;
        free_sum = '0; live_count = 0;
      end
      default: ;
    endcase
    r.free_sum = free_sum;
    r.count = live_count[fea_pkg::CNT_W-1:0];
    r.changes = changes;
    return r;
  endfunction

  // driver
  always @(posedge clk) begin
    if (rst_n) begin
      if (start && !busy) expected_results.push_back(allocate_step(pending_cmds.pop_front()));
      if ((start && !busy) || !start) begin
        if (pending_cmds.size() > 0 && !pause_req && (quiet || $urandom_range(99) >= 10)) begin
          start <= 1'b1;
          in_operation <= pending_cmds[0].op;
          in_address <= pending_cmds[0].addr;
          in_num_bytes <= pending_cmds[0].nbytes;
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    result_word_t e;
    cycles++;
    if (cycles > 1200000) begin
      $display("FAIL");
      $finish;
    end
    if (rst_n && out_valid) begin
      if (expected_results.size() == 0) begin
        failed = 1;
        mismatches++;
        if (mismatches <= 10) $display("unexpected result word at cycle %0d", cycles);
      end else begin
        e = expected_results.pop_front();
        if (out_status !== e.status || out_grant_address !== e.gaddr ||
            out_grant_bytes !== e.gbytes || out_free_bytes_total !== e.free_sum ||
            out_extent_count !== e.count || out_change_count !== e.changes) begin
          failed = 1;
          mismatches++;
          if (mismatches <= 10) begin
            $display("mismatch at cycle %0d", cycles);
            $display("  exp st=%0d ga=%h gb=%h free=%h cnt=%0d chg=%0d",
                     e.status, e.gaddr, e.gbytes, e.free_sum, e.count, e.changes);
            $display("  got st=%0d ga=%h gb=%h free=%h cnt=%0d chg=%0d",
                     out_status, out_grant_address, out_grant_bytes,
                     out_free_bytes_total, out_extent_count, out_change_count);
          end
        end
      end
    end
  end

  function automatic logic [fea_pkg::ADDR_W-1:0] rand_addr48();
    logic [63:0] w;
    w = {$urandom(), $urandom()};
    return w[fea_pkg::ADDR_W-1:0];
  endfunction

  task automatic push_cmd(logic [fea_pkg::OP_W-1:0] op, logic [fea_pkg::ADDR_W-1:0] a,
                          logic [fea_pkg::LEN_W-1:0] n);
    cmd_word_t c;
    c.op = op; c.addr = a; c.nbytes = n;
    pending_cmds.push_back(c);
  endtask

  task automatic drain();
    while (pending_cmds.size() > 0 || start || busy || expected_results.size() > 0)
      @(posedge clk);
    repeat (80) @(posedge clk);
  endtask

  task automatic write_reg(logic [fea_pkg::CIDX_W-1:0] idx, logic [fea_pkg::LEN_W-1:0] val);
    cfg_valid <= 1'b1; cfg_index <= idx; cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (idx == fea_pkg::CFG_BLOCK_LOG2) gran_log2 = int'(val[fea_pkg::BSL_W-1:0]);
    else merge_limit = val;
    @(posedge clk);
  endtask

  // well-formed workload in a small address window, plus noise
  task automatic random_phase(int items, int shift);
    int r;
    logic [fea_pkg::ADDR_W-1:0] a;
    logic [fea_pkg::LEN_W-1:0] n;
    for (int k = 0; k < items; k++) begin
      r = $urandom_range(99);
      a = {16'd0, $urandom_range(255) << shift};
      n = $urandom_range(16) << shift;
      if ($urandom_range(9) == 0) a = a + {44'd0, 4'($urandom_range(15))};
      if (r < 30) push_cmd(fea_pkg::OP_REQUEST, rand_addr48(), $urandom_range(8) << shift);
      else if (r < 55) push_cmd(fea_pkg::OP_RELEASE, a, n);
      else if (r < 70) push_cmd(fea_pkg::OP_CARVE, a, n);
      else if (r < 90) push_cmd(fea_pkg::OP_INSERT, a, n);
      else if (r < 92) push_cmd(fea_pkg::OP_CLEAR, rand_addr48(), $urandom());
      else if (r < 94) push_cmd(3'($urandom_range(5, 7)), rand_addr48(), $urandom());
      else if (r < 97) push_cmd(3'($urandom_range(3)), rand_addr48(), $urandom());
      else push_cmd(fea_pkg::OP_REQUEST, a, $urandom());
    end
  endtask

  initial begin
    for (int i = 0; i < fea_pkg::EXTENT_SLOTS; i++) ext_live[i] = 0;
    next_stamp = '0; free_sum = '0; live_count = 0; changes = '0;
    gran_log2 = int'(fea_pkg::BSL_RESET); merge_limit = fea_pkg::MAX_RESET;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed
    push_cmd(fea_pkg::OP_REQUEST, '0, 32'd100);
    push_cmd(fea_pkg::OP_CARVE, 48'h10, 32'd1);
    push_cmd(fea_pkg::OP_INSERT, 48'h1000, 32'h4000);
    push_cmd(fea_pkg::OP_INSERT, 48'h1000, 32'h10);
    push_cmd(fea_pkg::OP_RELEASE, 48'h1000, 32'h10);
    push_cmd(fea_pkg::OP_REQUEST, '0, 32'd1);
    push_cmd(fea_pkg::OP_RELEASE, 48'h1000, 32'h1000);
    push_cmd(fea_pkg::OP_RELEASE, 48'h5000, 32'h2000);
    push_cmd(fea_pkg::OP_CARVE, 48'h2000, 32'h1000);
    push_cmd(fea_pkg::OP_CARVE, 48'h1000, 32'h1000);
    push_cmd(fea_pkg::OP_CARVE, 48'h6000, 32'h1000);
    push_cmd(fea_pkg::OP_CARVE, 48'h6000, 32'hFFFF_FFFF);
    push_cmd(fea_pkg::OP_INSERT, 48'hFFFF_FFFF_FFFF, 32'hFFFF_FFFF);
    push_cmd(fea_pkg::OP_INSERT, 48'h8000, 32'd0);
    push_cmd(fea_pkg::OP_REQUEST, '0, 32'hFFFF_FFFF);
    push_cmd(fea_pkg::OP_REQUEST, '0, 32'd0);
    push_cmd(fea_pkg::OP_RELEASE, 48'h9000, 32'd0);
    push_cmd(3'd5, 48'hFFFF_FFFF_FFFF, 32'hFFFF_FFFF);
    push_cmd(3'd7, '0, '0);
    push_cmd(fea_pkg::OP_CLEAR, '0, '0);
    push_cmd(fea_pkg::OP_REQUEST, '0, 32'd5);
    drain();

    // fill the table to hit the full cases
    for (int i = 0; i < fea_pkg::EXTENT_SLOTS + 1; i++)
      push_cmd(fea_pkg::OP_INSERT, 48'(i) << 16, 32'h100);
    push_cmd(fea_pkg::OP_RELEASE, 48'h8000, 32'h10);
    push_cmd(fea_pkg::OP_RELEASE, 48'h100, 32'h100);
    push_cmd(fea_pkg::OP_CARVE, 48'h10, 32'h10);
    push_cmd(fea_pkg::OP_CLEAR, '0, '0);
    drain();

    random_phase(300, 12);
    quiet = 1;
    random_phase(150, 12);
    drain();
    quiet = 0;

    write_reg(fea_pkg::CFG_BLOCK_LOG2, 32'd0);
    write_reg(fea_pkg::CFG_MAX_EXTENT, 32'd1);
    random_phase(200, 0);
    // hold the sender until every outstanding result has come back
    while (pending_cmds.size() > 100) @(posedge clk);
    pause_req = 1;
    while (start || busy || expected_results.size() > 0) @(posedge clk);
    repeat (20) @(posedge clk);
    pause_req = 0;
    drain();

    write_reg(fea_pkg::CFG_BLOCK_LOG2, 32'd20);
    write_reg(fea_pkg::CFG_MAX_EXTENT, 32'hFFFF_FFFF);
    random_phase(200, 20);
    drain();

    write_reg(fea_pkg::CFG_BLOCK_LOG2, 32'd4);
    write_reg(fea_pkg::CFG_MAX_EXTENT, 32'h200);
    random_phase(200, 4);
    drain();

    write_reg(fea_pkg::CFG_BLOCK_LOG2, 32'd31);
    write_reg(fea_pkg::CFG_MAX_EXTENT, $urandom());
    random_phase(100, 8);
    drain();

    if (!failed && expected_results.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end
endmodule

@@ files.f @@
hdl/fea_pkg.sv
hdl/fea_ctrl.sv
hdl/fea_dp.sv
hdl/free_extent_allocator.sv
tb/sv/tb.sv
